@@ rtl/core/aes256_pkg.sv @@
// aes256_pkg: shared constants, types and gf/s-box functions for the aes-256 core
// no dependencies

package aes256_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RkWords   = 4 * (NumRounds + 1);
  localparam int unsigned RkAddrW   = $clog2(RkWords);
  localparam int unsigned RoundW    = $clog2(NumRounds + 1);
  localparam int unsigned CfgIdxW   = 2;

  // configuration register indexes
  localparam logic [1:0] RegKey0 = 2'd0;
  localparam logic [1:0] RegKey1 = 2'd1;
  localparam logic [1:0] RegKey2 = 2'd2;
  localparam logic [1:0] RegKey3 = 2'd3;

  // command codes
  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  // per-cycle control handed from the sequencer to the column cells
  typedef struct packed {
    logic load;
    logic decrypt;
    logic last;
  } cell_ctrl_t;

  // multiply by x in gf(2^8), polynomial 0x11b
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = a;
    // exponent 254 = 0b11111110
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int unsigned n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05;
    inv_sbox_calc = gf_inv(b);
  endfunction

  typedef logic [7:0] sbox_rom_t [256];

  function automatic sbox_rom_t gen_sbox(input logic inverse);
    sbox_rom_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    gen_sbox = t;
  endfunction

  localparam sbox_rom_t SboxRom    = gen_sbox(1'b0);
  localparam sbox_rom_t InvSboxRom = gen_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SboxRom[w[31:24]], SboxRom[w[23:16]], SboxRom[w[15:8]], SboxRom[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[7:0];
    a1 = w[15:8];
    a2 = w[23:16];
    a3 = w[31:24];
    mix_word = {xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2,
                xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1,
                xtime(a1) ^ xtime(a2) ^ a2 ^ a0 ^ a3,
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3};
  endfunction

  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[7:0];
    a1 = w[15:8];
    a2 = w[23:16];
    a3 = w[31:24];
    inv_mix_word = {
      gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14),
      gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
      gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
      gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9)};
  endfunction

endpackage

@@ rtl/core/aes256_col_cell.sv @@
// aes256_col_cell: one state column of the round chain, holds 32 bits
// depends on aes256_pkg

module aes256_col_cell import aes256_pkg::*; (
  input  logic        clk_i,
  input  cell_ctrl_t  ctrl_i,
  input  logic [31:0] load_i,
  input  logic [31:0] key_i,
  // bytes handed over by the neighbor columns: row 1, 2, 3 sources
  input  logic [7:0]  row1_i,
  input  logic [7:0]  row2_i,
  input  logic [7:0]  row3_i,
  output logic [31:0] col_o
);

  logic [31:0] col_q, col_d;
  logic [31:0] sub_w, mix_w, fwd_w;

  // sub bytes after row shift, mix unless last round, load, key add
  always_comb begin
    sub_w[7:0]   = ctrl_i.decrypt ? InvSboxRom[col_q[7:0]] : SboxRom[col_q[7:0]];
    sub_w[15:8]  = ctrl_i.decrypt ? InvSboxRom[row1_i]     : SboxRom[row1_i];
    sub_w[23:16] = ctrl_i.decrypt ? InvSboxRom[row2_i]     : SboxRom[row2_i];
    sub_w[31:24] = ctrl_i.decrypt ? InvSboxRom[row3_i]     : SboxRom[row3_i];
    mix_w        = ctrl_i.decrypt ? inv_mix_word(sub_w)    : mix_word(sub_w);
    fwd_w        = ctrl_i.last ? sub_w : mix_w;
    col_d        = (ctrl_i.load ? load_i : fwd_w) ^ key_i;
  end

  // column register
  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;

endmodule

@@ rtl/core/aes256_key_exp.sv @@
// aes256_key_exp: key schedule, fills encryption and decryption round-key memories
// depends on aes256_pkg

module aes256_key_exp import aes256_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [255:0]       key_i,
  output logic               busy_o,
  input  logic               rd_dec_i,
  input  logic [RoundW-1:0]  rd_round_i,
  output logic [127:0]       rd_key_o
);

  typedef enum logic [1:0] {KxIdle, KxEnc, KxDec} kx_state_e;

  localparam int unsigned NumKeyRounds = NumRounds + 1;

  kx_state_e         state_q;
  logic [5:0]        idx_q;       // word index during expansion
  logic [RoundW-1:0] rnd_q;       // round index during decryption fill
  logic [1:0]        col_q;
  logic [7:0]        rcon_q;
  logic [255:0]      win_q;       // last eight words, word 0 oldest

  // memories: one row of four words per round
  logic [127:0] enc_mem [NumKeyRounds];
  logic [127:0] dec_mem [NumKeyRounds];
  logic [127:0] enc_rd_q, dec_rd_q;
  logic [RoundW-1:0] enc_ra, dec_wa;
  logic [127:0] dec_row;
  logic         rd_sel_q;

  logic [31:0] prev_w, t_w, new_w;
  logic [2:0]  pos;

  // next expanded word
  always_comb begin
    prev_w = win_q[255:224];
    pos    = idx_q[2:0];
    if (pos == 3'd0) begin
      t_w = sub_word({prev_w[7:0], prev_w[31:8]}) ^ {24'h0, rcon_q};
    end else if (pos == 3'd4) begin
      t_w = sub_word(prev_w);
    end else begin
      t_w = prev_w;
    end
    new_w = win_q[31:0] ^ t_w;
  end

  // decryption row built from the enc row read last cycle
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dec_row[32*k +: 32] = ((rnd_q == '0) || (rnd_q == RoundW'(NumRounds))) ?
                            enc_rd_q[32*k +: 32] : inv_mix_word(enc_rd_q[32*k +: 32]);
    end
  end

  assign enc_ra = (state_q == KxDec) ? RoundW'(RoundW'(NumRounds) - rnd_q - RoundW'(1'b0))
                                     : rd_round_i;
  assign dec_wa = rnd_q;

  // sequencer; a new start restarts the schedule from any state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KxIdle;
      idx_q   <= '0;
      rnd_q   <= '0;
      col_q   <= '0;
      rcon_q  <= 8'h01;
    end else if (start_i) begin
      state_q <= KxEnc;
      idx_q   <= 6'd8;
      col_q   <= '0;
      rcon_q  <= 8'h01;
    end else begin
      case (state_q)
        KxIdle: ;
        KxEnc: begin
          if (pos == 3'd0) rcon_q <= xtime(rcon_q);
          idx_q <= idx_q + 6'd1;
          if (idx_q == 6'(RkWords - 1)) begin
            state_q <= KxDec;
            rnd_q   <= '0;
            col_q   <= '0;
          end
        end
        KxDec: begin
          // col_q marks read phase (0) and write phase (1)
          col_q <= col_q ^ 2'd1;
          if (col_q[0]) begin
            if (rnd_q == RoundW'(NumRounds)) begin
              state_q <= KxIdle;
            end else begin
              rnd_q <= rnd_q + RoundW'(1);
            end
          end
        end
        default: state_q <= KxIdle;
      endcase
    end
  end

  // word window, memory writes and registered memory reads
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      win_q <= key_i;
      enc_mem[0] <= key_i[127:0];
      enc_mem[1] <= key_i[255:128];
    end else if (state_q == KxEnc) begin
      win_q <= {new_w, win_q[255:32]};
      if (idx_q[1:0] == 2'd3) begin
        enc_mem[idx_q[5:2]] <= {new_w, win_q[255:160]};
      end
    end
    if (state_q == KxDec && col_q[0]) begin
      dec_mem[dec_wa] <= dec_row;
    end
    enc_rd_q <= enc_mem[enc_ra];
    dec_rd_q <= dec_mem[rd_round_i];
    rd_sel_q <= rd_dec_i;
  end

  assign busy_o   = (state_q != KxIdle);
  assign rd_key_o = rd_sel_q ? dec_rd_q : enc_rd_q;

endmodule

@@ rtl/core/aes256_block_cipher_top.sv @@
// aes256_block_cipher_top: aes-256 ecb encrypt/decrypt core
// depends on aes256_pkg, aes256_key_exp, aes256_col_cell
//
// usage
//   config port: cfg_we_i with cfg_idx_i 0..3 writes one 64-bit key word;
//   any write to a key word starts key expansion (the schedule words,
//   then a read and a write phase per decryption round key);
//   a write during expansion restarts it. write only while idle.
//   input channel: in_valid_i/in_ready_o with cmd_i, block_lo_i, block_hi_i.
//   output channel: out_valid_o/out_ready_i with result_lo_o, result_hi_o.
//   one word at a time: ready drops while a word is in the round chain.
//   from accept to result valid: a key fetch, the initial key add, 14
//   rounds through the four column cells, then a move of the result into
//   the output register.
//   a new word is taken only once the last one has left the round loop
//   and the sequencer is back in idle, where ready comes back.
//   reset: control cleared; the first word after reset expands the all-zero
//   key first.
//   stall: the result is held in the output register until taken; the next
//   word is accepted while it waits, and its result waits for the port.

module aes256_block_cipher_top import aes256_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [63:0]        block_lo_i,
  input  logic [63:0]        block_hi_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        result_lo_o,
  output logic [63:0]        result_hi_o
);

  typedef enum logic [1:0] {StIdle, StFetch, StRound, StDone} state_e;

  state_e            state_q;
  logic [63:0]       key_q [4];
  logic              expanded_q;
  logic              kx_start;
  logic              kx_busy;
  logic [RoundW-1:0] rnd_q;
  logic              dec_q;
  logic [127:0]      blk_q;
  logic [127:0]      rk;
  logic              out_valid_q;
  logic [127:0]      out_q;
  logic              cfg_hit;
  logic              accept;
  cell_ctrl_t        ctrl;
  logic [31:0]       col [4];

  // every index of the two-bit field names a key word
  assign cfg_hit  = cfg_we_i;
  assign accept   = in_valid_i && in_ready_o;
  assign kx_start = cfg_hit || (accept && !expanded_q);

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i[1:0])
        RegKey0: key_q[0] <= cfg_data_i;
        RegKey1: key_q[1] <= cfg_data_i;
        RegKey2: key_q[2] <= cfg_data_i;
        RegKey3: key_q[3] <= cfg_data_i;
        default: key_q[0] <= cfg_data_i;
      endcase
    end
  end

  // key schedule; a config write lands next cycle, so feed the new value
  logic [255:0] kx_key;
  always_comb begin
    kx_key = {key_q[3], key_q[2], key_q[1], key_q[0]};
    if (cfg_hit) kx_key[64*cfg_idx_i[1:0] +: 64] = cfg_data_i;
  end

  aes256_key_exp u_key_exp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kx_start),
    .key_i      (kx_key),
    .busy_o     (kx_busy),
    .rd_dec_i   (dec_q),
    .rd_round_i (rnd_q),
    .rd_key_o   (rk)
  );

  // round sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      expanded_q  <= 1'b0;
      rnd_q       <= '0;
      dec_q       <= CmdEncrypt;
      out_valid_q <= 1'b0;
    end else begin
      if (kx_start) expanded_q <= 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StFetch;
            rnd_q   <= '0;
            dec_q   <= cmd_i;
          end
        end
        StFetch: begin
          // wait for any expansion, then key of round 0 is read
          if (!kx_busy) begin
            state_q <= StRound;
            rnd_q   <= rnd_q + RoundW'(1);
          end
        end
        StRound: begin
          if (rnd_q == RoundW'(NumRounds) + RoundW'(1)) begin
            state_q <= StDone;
          end else begin
            rnd_q <= rnd_q + RoundW'(1);
          end
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (accept) blk_q <= {block_hi_i, block_lo_i};
    if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
      out_q <= {col[3], col[2], col[1], col[0]};
    end
  end

  // rnd_q is one ahead of the key that the memory presents;
  // outside the round state the cells reload their own column and hold
  assign ctrl.load    = (state_q != StRound) || (rnd_q == RoundW'(1));
  assign ctrl.decrypt = dec_q;
  assign ctrl.last    = (rnd_q == RoundW'(NumRounds) + RoundW'(1));
  logic cell_en;
  assign cell_en = (state_q == StRound);

  // four column cells; row r of column c comes from column c+r (enc) or c-r (dec)
  for (genvar c = 0; c < 4; c++) begin : g_col
    logic [31:0] cell_out;
    logic [7:0]  r1, r2, r3;
    assign r1 = dec_q ? col[(c + 3) % 4][15:8]  : col[(c + 1) % 4][15:8];
    assign r2 = col[(c + 2) % 4][23:16];
    assign r3 = dec_q ? col[(c + 1) % 4][31:24] : col[(c + 3) % 4][31:24];
    aes256_col_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .load_i (cell_en ? blk_q[32*c +: 32] : col[c]),
      .key_i  (cell_en ? rk[32*c +: 32] : 32'h0),
      .row1_i (r1),
      .row2_i (r2),
      .row3_i (r3),
      .col_o  (cell_out)
    );
    assign col[c] = cell_out;
  end

  assign in_ready_o  = (state_q == StIdle) && !kx_busy;
  assign out_valid_o = out_valid_q;
  assign result_lo_o = out_q[63:0];
  assign result_hi_o = out_q[127:64];

  // checks
  a_no_round_during_kx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> !kx_busy) else $error("round ran during key expansion");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> (state_q == StDone) || (state_q == StIdle))
    else $error("done state left wrongly");
  a_accept_expands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> expanded_q) else $error("keys not expanded after accept");

endmodule
